// ----- rtl/utf8_display_width_counter_macros.svh -----
// Assertion macros for the UTF-8 display width counter.
// Used by utf8_display_width_counter.sv; expects clk and rst_n in scope.
`ifndef UTF8_DISPLAY_WIDTH_COUNTER_MACROS_SVH
`define UTF8_DISPLAY_WIDTH_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8DW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define U8DW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/u8dw_pkg.sv -----
// Shared types, constants and the display width classifier for the
// UTF-8 display width counter. No dependencies.
package u8dw_pkg;

  localparam int SUM_BITS = 16;
  localparam int CP_BITS  = 21;
  localparam int OUT_BITS = 16;
  localparam int REM_BITS = 2;

  typedef logic [CP_BITS-1:0]  cp_t;
  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [OUT_BITS-1:0] total_t;
  typedef logic [1:0]          colw_t;   // columns of one code point: 0..2

  // Decoder state carried between bytes.
  typedef struct packed {
    cp_t                 partial;
    logic [REM_BITS-1:0] rem;
  } dec_state_t;

  // Terminal columns of one code point.
  function automatic colw_t cell_width(cp_t cp);
    colw_t w;
    w = 2'd1;
    if (cp < 21'h20 || cp inside {[21'h7F:21'h9F]} || cp inside {[21'h0300:21'h036F]}) begin
      w = 2'd0;
    end else if (cp inside {[21'h1100:21'h115F]} || cp == 21'h2329 || cp == 21'h232A ||
                 (cp inside {[21'h2E80:21'hA4CF]} && cp != 21'h303F) ||
                 cp inside {[21'hAC00:21'hD7A3]} || cp inside {[21'hF900:21'hFAFF]} ||
                 cp inside {[21'hFE10:21'hFE19]} || cp inside {[21'hFE30:21'hFE6F]} ||
                 cp inside {[21'hFF00:21'hFF60]} || cp inside {[21'hFFE0:21'hFFE6]} ||
                 cp inside {[21'h1F300:21'h1F64F]} || cp inside {[21'h1F900:21'h1F9FF]}) begin
      w = 2'd2;
    end
    return w;
  endfunction

  // Clamp the running sum to the output field.
  function automatic total_t sat_total(sum_t s);
    total_t t;
    if (33'(s) > 33'({OUT_BITS{1'b1}})) begin
      t = {OUT_BITS{1'b1}};
    end else begin
      t = OUT_BITS'(s);
    end
    return t;
  endfunction

endpackage

// ----- rtl/utf8_display_width_counter.sv -----
// Top level of the UTF-8 display width counter.
// Depends on u8dw_pkg, u8dw_step and utf8_display_width_counter_macros.svh.
//
//  channel  ports                               transfer when
//  input    in_byte_in[7:0], in_last_byte       in_valid & in_ready
//  result   out_total_width[15:0]               out_valid & out_ready
//
// One byte per cycle while no last byte is blocked. A byte is held in the input register,
// then decode, width lookup and saturating add update the state in one step.
// The total is registered at the end of the cycle that decodes its last byte;
// a last byte passes the input register, then the output register, to out_valid.
// rst_n is synchronous, active low, and clears all control state and the sum.
// Input stalls only while a last byte waits on a full, unaccepted result.
`include "utf8_display_width_counter_macros.svh"

module utf8_display_width_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_total_width
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_fire;

  // decoder state and running sum
  u8dw_pkg::dec_state_t dec_r, dec_nxt, step_nxt;
  u8dw_pkg::sum_t       sum_r, sum_nxt;
  logic [2:0]           add_cols;
  logic [u8dw_pkg::SUM_BITS:0] sum_wide;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  u8dw_pkg::total_t     out_total_width_r;

  // The decode stage moves unless it holds a last byte and the result slot
  // is full and not being drained this cycle.
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  u8dw_step u_step (
    .byte_in  (s1_byte_r),
    .cur      (dec_r),
    .nxt      (step_nxt),
    .add_cols (add_cols)
  );

  // Saturating accumulate; a last byte drops any unfinished sequence and
  // starts the next string from clean state.
  always_comb begin
    sum_wide = {1'b0, sum_r} + (u8dw_pkg::SUM_BITS+1)'(add_cols);
    if (sum_wide[u8dw_pkg::SUM_BITS]) begin
      sum_nxt = {u8dw_pkg::SUM_BITS{1'b1}};
    end else begin
      sum_nxt = sum_wide[u8dw_pkg::SUM_BITS-1:0];
    end
    dec_nxt = step_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dec_r       <= '0;
      sum_r       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        if (s1_last_r) begin
          dec_r <= '0;
          sum_r <= '0;
        end else begin
          dec_r <= dec_nxt;
          sum_r <= sum_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last_byte;
    end
    if (s1_fire && s1_last_r) begin
      out_total_width_r <= u8dw_pkg::sat_total(sum_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_total_width = out_total_width_r;

  `U8DW_ASSERT_NEXT(a_clear_after_last, s1_fire && s1_last_r,
                    sum_r == '0 && dec_r == '0, "state not cleared after last byte")
  `U8DW_ASSERT_NEXT(a_sum_monotonic, s1_fire && !s1_last_r,
                    sum_r >= $past(sum_r), "running sum decreased inside a string")
  `U8DW_ASSERT_NOW(a_stall_cause, !in_ready,
                   s1_valid_r && s1_last_r && out_valid_r && !out_ready,
                   "input stalled without a blocked result")
  `U8DW_ASSERT_NOW(a_four_byte_lead, dec_r.rem == 2'd3, dec_r.partial < 21'd8,
                   "four-byte lead holds more than three bits")

endmodule

// ----- rtl/u8dw_step.sv -----
// One decode step: byte plus decoder state gives next state and columns.
// Depends on u8dw_pkg.
module u8dw_step (
  input  logic [7:0]           byte_in,
  input  u8dw_pkg::dec_state_t cur,
  output u8dw_pkg::dec_state_t nxt,
  output logic [2:0]           add_cols
);

  logic                 is_cont;
  u8dw_pkg::dec_state_t base;
  u8dw_pkg::cp_t        shifted;
  logic [2:0]           pre_add;

  assign is_cont = (byte_in[7:6] == 2'b10);
  assign shifted = u8dw_pkg::CP_BITS'({cur.partial, byte_in[5:0]});

  always_comb begin
    nxt      = cur;
    add_cols = 3'd0;
    base     = cur;
    pre_add  = 3'd0;
    if (cur.rem != '0 && is_cont) begin
      // continuation: shift in six bits, score when the sequence completes
      nxt.partial = shifted;
      nxt.rem     = cur.rem - 1'b1;
      if (cur.rem == 2'd1) begin
        add_cols = {1'b0, u8dw_pkg::cell_width(shifted)};
      end
    end else begin
      if (cur.rem != '0) begin
        // broken sequence: replacement char, then reparse this byte as a lead
        pre_add      = 3'd1;
        base.partial = '0;
        base.rem     = '0;
      end
      nxt      = base;
      add_cols = pre_add;
      if (!byte_in[7]) begin
        add_cols = pre_add + {1'b0, u8dw_pkg::cell_width(u8dw_pkg::CP_BITS'(byte_in))};
      end else if (byte_in[7:5] == 3'b110) begin
        nxt.partial = u8dw_pkg::CP_BITS'(byte_in[4:0]);
        nxt.rem     = 2'd1;
      end else if (byte_in[7:4] == 4'b1110) begin
        nxt.partial = u8dw_pkg::CP_BITS'(byte_in[3:0]);
        nxt.rem     = 2'd2;
      end else if (byte_in[7:3] == 5'b11110) begin
        nxt.partial = u8dw_pkg::CP_BITS'(byte_in[2:0]);
        nxt.rem     = 2'd3;
      end else begin
        add_cols = pre_add + 3'd1;
      end
    end
  end

endmodule
